>>> rtl/fpda_pkg.sv
// Shared types and constants for the decimal fixed-point ALU.
// No dependencies; fpda_mul, fpda_div and the top level import this package.
`default_nettype none
package fpda_pkg;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1,
    OP_ADJ = 2'd2,
    OP_NOP = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;

  localparam logic [63:0] BPS_UNIT = 64'd10000;

  // Sideband that travels with each word down the pipeline.
  typedef struct packed {
    logic       neg;     // result sign
    logic       zero;    // force a zero result (div by zero or unused op)
    logic [1:0] status;  // status decided at decode
  } tag_t;

endpackage
`default_nettype wire

>>> rtl/fpda_if.sv
// Handshake channels for the decimal fixed-point ALU: request and response.
// Depends on nothing.
`default_nettype none
interface fpda_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [63:0] operand_a;
  logic signed [63:0] operand_b;
  logic signed [31:0] basis_points;
  modport source (output valid, op, operand_a, operand_b, basis_points, input ready);
  modport sink   (input valid, op, operand_a, operand_b, basis_points, output ready);
endinterface

interface fpda_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] result;
  logic [1:0]         status;
  modport source (output valid, result, status, input ready);
  modport sink   (input valid, result, status, output ready);
endinterface
`default_nettype wire

>>> rtl/fpda_mul.sv
// Two-stage unsigned 64x64 multiplier: 32x32 partial products, then the sum.
// Carries divisor, tag and valid alongside. Uses fpda_pkg.
`default_nettype none
module fpda_mul (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          valid_in,
  input  wire logic [63:0]   x,
  input  wire logic [63:0]   y,
  input  wire logic [63:0]   d_in,
  input  wire fpda_pkg::tag_t tag_in,
  output logic               valid_out,
  output logic [127:0]       prod,
  output logic [63:0]        d_out,
  output fpda_pkg::tag_t     tag_out
);
  import fpda_pkg::*;

  logic [63:0] p00, p01, p10, p11;
  logic [63:0] d1;
  tag_t        tag1;
  logic        valid1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1    <= 1'b0;
      valid_out <= 1'b0;
    end else if (en) begin
      valid1    <= valid_in;
      valid_out <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p00     <= x[31:0]  * y[31:0];
      p01     <= x[31:0]  * y[63:32];
      p10     <= x[63:32] * y[31:0];
      p11     <= x[63:32] * y[63:32];
      d1      <= d_in;
      tag1    <= tag_in;
      prod    <= {64'd0, p00} + {32'd0, p01, 32'd0} + {32'd0, p10, 32'd0} + {p11, 64'd0};
      d_out   <= d1;
      tag_out <= tag1;
    end
  end

endmodule
`default_nettype wire

>>> rtl/fpda_div.sv
// Pipelined 128/64 restoring divider with a 64-bit quotient and a range check.
// One compare stage, then STEPS quotient bits per stage. Uses fpda_pkg.
`default_nettype none
module fpda_div (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          valid_in,
  input  wire logic [127:0]  prod,
  input  wire logic [63:0]   d_in,
  input  wire fpda_pkg::tag_t tag_in,
  output logic               valid_out,
  output logic [63:0]        quot,
  output logic               big,
  output fpda_pkg::tag_t     tag_out
);
  import fpda_pkg::*;

  localparam int STEPS = 4;
  localparam int NSTG  = 64 / STEPS;

  // Index 0 is the compare stage; stage k holds the state after k*STEPS bits.
  logic        vld [NSTG+1];
  logic [63:0] rem [NSTG+1];
  logic [63:0] sh  [NSTG+1];  // dividend bits out the top, quotient in the bottom
  logic [63:0] dv  [NSTG+1];
  logic        ovf [NSTG+1];
  tag_t        tg  [NSTG+1];

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= valid_in;
  end

  // Quotient reaches 2^64 exactly when the upper half is at least the divisor.
  always_ff @(posedge clk) begin
    if (en) begin
      ovf[0] <= prod[127:64] >= d_in;
      rem[0] <= prod[127:64];
      sh[0]  <= prod[63:0];
      dv[0]  <= d_in;
      tg[0]  <= tag_in;
    end
  end

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic [63:0] r_c;
    logic [63:0] q_c;

    always_comb begin
      logic [64:0] t;
      r_c = rem[s];
      q_c = sh[s];
      for (int k = 0; k < STEPS; k++) begin
        t   = {r_c, q_c[63]};
        q_c = {q_c[62:0], 1'b0};
        if (t >= {1'b0, dv[s]}) begin
          t      = t - {1'b0, dv[s]};
          q_c[0] = 1'b1;
        end
        r_c = t[63:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) vld[s+1] <= 1'b0;
      else if (en) vld[s+1] <= vld[s];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= r_c;
        sh[s+1]  <= q_c;
        dv[s+1]  <= dv[s];
        ovf[s+1] <= ovf[s];
        tg[s+1]  <= tg[s];
      end
    end
  end

  assign valid_out = vld[NSTG];
  assign quot      = sh[NSTG];
  assign big       = ovf[NSTG];
  assign tag_out   = tg[NSTG];

endmodule
`default_nettype wire

>>> rtl/fixed_point_decimal_alu.sv
// Top level of the decimal fixed-point ALU: decode, multiplier, divider, output.
// Depends on fpda_pkg, fpda_if, fpda_mul and fpda_div.
//
// Usage:
//   req carries op, operand_a, operand_b and basis_points; rsp carries result
//   and status. A word moves when valid and ready are both high.
//   Multiply gives a*b/FRACTION_SCALE, divide a*FRACTION_SCALE/b, adjust
//   a*(10000+bps)/10000, all truncated toward zero. Status 1 flags a result
//   outside signed 64 bits, status 2 a zero divisor; result is then zero.
//   The pipeline has one decode stage, two multiplier stages, one range
//   compare, sixteen divider stages of four quotient bits each and the output
//   register. One word enters per cycle while the output is not stalled; the
//   64-bit quotient built four bits per stage sets the depth.
//   The pipeline advances as a whole: when the output word waits on a low
//   rsp.ready, every stage holds and req.ready drops, so nothing is lost or
//   repeated. Reset clears all valid bits; the data registers are not reset.
`default_nettype none
module fixed_point_decimal_alu #(
  parameter int FRACTION_SCALE = 1000000
) (
  input wire logic  clk,
  input wire logic  rst,
  fpda_req_if.sink  req,
  fpda_rsp_if.source rsp
);
  import fpda_pkg::*;

  logic en;
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  // Decode
  logic        a_neg, b_neg, f_neg;
  logic [63:0] a_mag, b_mag;
  logic [32:0] factor;
  logic [63:0] f_mag;
  logic [63:0] x_c, y_c, d_c;
  tag_t        tag_c;

  always_comb begin
    a_neg  = req.operand_a[63];
    b_neg  = req.operand_b[63];
    a_mag  = a_neg ? (~req.operand_a + 64'd1) : req.operand_a;
    b_mag  = b_neg ? (~req.operand_b + 64'd1) : req.operand_b;
    factor = 33'(BPS_UNIT) + {req.basis_points[31], req.basis_points};
    f_neg  = factor[32];
    f_mag  = {31'd0, f_neg ? (~factor + 33'd1) : factor};
    x_c    = a_mag;
    y_c    = 64'd0;
    d_c    = 64'd1;
    tag_c  = '{neg: 1'b0, zero: 1'b0, status: ST_OK};
    case (op_t'(req.op))
      OP_MUL: begin
        y_c       = b_mag;
        d_c       = 64'(FRACTION_SCALE);
        tag_c.neg = a_neg ^ b_neg;
      end
      OP_DIV: begin
        y_c       = 64'(FRACTION_SCALE);
        tag_c.neg = a_neg ^ b_neg;
        if (req.operand_b == 64'sd0) begin
          tag_c.zero   = 1'b1;
          tag_c.status = ST_DIV_ZERO;
        end else begin
          d_c = b_mag;
        end
      end
      OP_ADJ: begin
        y_c       = f_mag;
        d_c       = BPS_UNIT;
        tag_c.neg = a_neg ^ f_neg;
      end
      default: tag_c.zero = 1'b1;
    endcase
  end

  logic        dec_valid;
  logic [63:0] dec_x, dec_y, dec_d;
  tag_t        dec_tag;

  always_ff @(posedge clk) begin
    if (rst) dec_valid <= 1'b0;
    else if (en) dec_valid <= req.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dec_x   <= x_c;
      dec_y   <= y_c;
      dec_d   <= d_c;
      dec_tag <= tag_c;
    end
  end

  logic          mul_valid;
  logic [127:0]  mul_prod;
  logic [63:0]   mul_d;
  tag_t          mul_tag;

  fpda_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (dec_valid),
    .x         (dec_x),
    .y         (dec_y),
    .d_in      (dec_d),
    .tag_in    (dec_tag),
    .valid_out (mul_valid),
    .prod      (mul_prod),
    .d_out     (mul_d),
    .tag_out   (mul_tag)
  );

  logic        div_valid;
  logic [63:0] div_q;
  logic        div_big;
  tag_t        div_tag;

  fpda_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (mul_valid),
    .prod      (mul_prod),
    .d_in      (mul_d),
    .tag_in    (mul_tag),
    .valid_out (div_valid),
    .quot      (div_q),
    .big       (div_big),
    .tag_out   (div_tag)
  );

  // Range check and sign
  logic        range_ovf;
  logic [63:0] res_c;
  logic [1:0]  st_c;

  always_comb begin
    range_ovf = div_big || (div_tag.neg ? (div_q > 64'h8000_0000_0000_0000)
                                        : div_q[63]);
    res_c = div_tag.neg ? (~div_q + 64'd1) : div_q;
    st_c  = ST_OK;
    if (div_tag.zero) begin
      res_c = 64'd0;
      st_c  = div_tag.status;
    end else if (range_ovf) begin
      res_c = 64'd0;
      st_c  = ST_OVERFLOW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) rsp.valid <= 1'b0;
    else if (en) rsp.valid <= div_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.result <= res_c;
      rsp.status <= st_c;
    end
  end

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |-> rsp.result == 64'sd0)
    else $error("nonzero result with error status");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    req.ready == (!rsp.valid || rsp.ready))
    else $error("ready does not follow output stall");

  a_rst: assert property (@(posedge clk) rst |=> !rsp.valid && !u_div.valid_out)
    else $error("valid survives reset");
`endif

endmodule
`default_nettype wire
